// File: design/msit_pkg.sv
// Package for the multi-slot interval timer: codes, types and sizes.
`timescale 1ns / 1ps
`default_nettype none
package msit_pkg;
  localparam int SLOTS_DEF = 8;
  localparam int MAX_FIRES = 8;
  localparam int FQ_DEPTH  = 2;

  typedef enum logic [3:0] {
    FN_CREATE = 4'd0, FN_PAUSE = 4'd1, FN_RESUME = 4'd2, FN_QUERY = 4'd3,
    FN_TRIGDEL = 4'd4, FN_CANCEL = 4'd5, FN_SETCNT = 4'd6, FN_SETIVL = 4'd7,
    FN_TICK = 4'd8
  } func_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  slot;
    logic [15:0] count;
    logic [31:0] interval_ms;
    logic [31:0] tick_ms;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [2:0] result_slot;
    logic       fired;
    logic       running;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0, ST_CMD = 2'd1, ST_SCAN = 2'd2, ST_FLUSH = 2'd3
  } bstate_t;
endpackage
`default_nettype wire

// File: design/msit_front.sv
// Front end: accepts items, drops zero ticks, queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module msit_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire msit_pkg::cmd_t in_cmd,
  output logic                q_valid,
  output msit_pkg::cmd_t      q_cmd,
  input  wire logic           q_take,
  output logic                busy
);
  localparam int D = msit_pkg::FQ_DEPTH;
  msit_pkg::cmd_t mem_r [D];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic acc, keep;

  assign full    = (cnt_r == 2'(D));
  assign acc     = push && !full;
  // zero tick is dropped here, so it never enters the queue
  assign keep    = acc && !(in_cmd.func == msit_pkg::FN_TICK && in_cmd.tick_ms == '0);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];
  assign busy    = q_valid;

  always_comb begin
    wp_nxt  = keep ? ~wp_r : wp_r;
    rp_nxt  = (q_take && q_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(keep) - 2'(q_take && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) mem_r[wp_r] <= in_cmd;
  end
endmodule
`default_nettype wire

// File: design/msit_back.sv
// Back end: slot table, command execution, tick scan one slot a cycle while the result queue has room, result queue.
`timescale 1ns / 1ps
`default_nettype none
module msit_back #(
  parameter int SLOTS = msit_pkg::SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire msit_pkg::cmd_t q_cmd,
  output logic                q_take,
  output logic                empty,
  input  wire logic           pop,
  output msit_pkg::res_t      res
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RQ = 2;

  logic [SLOTS-1:0] in_use_r, in_use_nxt, run_r, run_nxt, endl_r, endl_nxt;
  logic [15:0] rem_r [SLOTS];
  logic [31:0] per_r [SLOTS];
  logic [31:0] ela_r [SLOTS];
  logic [SW-1:0] nf_r, nf_nxt;
  logic full_r, full_nxt;
  msit_pkg::bstate_t st_r, st_nxt;
  msit_pkg::cmd_t cmd_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [3:0] nf_cnt_r, nf_cnt_nxt;
  // one fire result held back so the final one can carry last
  logic pend_r, pend_nxt;
  logic [2:0] pend_slot_r, pend_slot_nxt;

  msit_pkg::res_t rq_r [RQ];
  logic rwp_r, rrp_r;
  logic [1:0] rcnt_r;
  logic rpush;
  msit_pkg::res_t rdata;
  logic rq_room;

  logic [SW-1:0] tgt;
  logic tgt_ok;
  logic [31:0] esum;
  logic [15:0] rdec;
  logic wr_ela, wr_rem, wr_per, wr_new;
  logic [31:0] ela_val, per_val;
  logic [15:0] rem_val;
  logic [SW-1:0] widx;
  logic [SW-1:0] srch;
  logic srch_ok;
  logic last_slot;

  assign rq_room = (rcnt_r != 2'(RQ));
  assign empty   = (rcnt_r == 2'd0);
  assign res     = rq_r[rrp_r];
  assign q_take  = (st_r == msit_pkg::ST_IDLE) && q_valid;

  assign tgt    = SW'(cmd_r.slot);
  assign tgt_ok = ({29'd0, cmd_r.slot} < 32'(SLOTS)) && in_use_r[tgt];
  assign esum   = ela_r[idx_r] + cmd_r.tick_ms;
  assign rdec   = rem_r[idx_r] - 16'd1;
  assign last_slot = (32'(idx_r) == 32'(SLOTS - 1));

  // round-robin free-slot search after create; in_use with the new slot set
  always_comb begin
    logic [SLOTS-1:0] u;
    logic [SW-1:0] k;
    logic [31:0] sum;
    u = in_use_r;
    u[nf_r] = 1'b1;
    srch = nf_r;
    srch_ok = 1'b0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      sum = 32'(nf_r) + 32'(i);
      if (sum >= 32'(SLOTS)) sum = sum - 32'(SLOTS);
      k = SW'(sum);
      if (!u[k]) begin
        srch = k;
        srch_ok = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      msit_pkg::ST_IDLE: if (q_valid) st_nxt = (q_cmd.func == msit_pkg::FN_TICK) ?
                                               msit_pkg::ST_SCAN : msit_pkg::ST_CMD;
      msit_pkg::ST_CMD:  if (rq_room) st_nxt = msit_pkg::ST_IDLE;
      msit_pkg::ST_SCAN: if (rq_room && last_slot) st_nxt = msit_pkg::ST_FLUSH;
      msit_pkg::ST_FLUSH: if (rq_room) st_nxt = msit_pkg::ST_IDLE;
      default: st_nxt = msit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    logic fire, act;
    in_use_nxt = in_use_r; run_nxt = run_r; endl_nxt = endl_r;
    nf_nxt = nf_r; full_nxt = full_r;
    idx_nxt = idx_r; nf_cnt_nxt = nf_cnt_r;
    pend_nxt = pend_r; pend_slot_nxt = pend_slot_r;
    rpush = 1'b0; rdata = '0;
    wr_ela = 1'b0; wr_rem = 1'b0; wr_per = 1'b0; wr_new = 1'b0;
    ela_val = '0; per_val = '0; rem_val = '0; widx = idx_r;
    fire = 1'b0; act = 1'b0;
    case (st_r)
      msit_pkg::ST_IDLE: begin
        idx_nxt = '0; nf_cnt_nxt = '0; pend_nxt = 1'b0;
      end
      msit_pkg::ST_CMD: if (rq_room) begin
        rpush = 1'b1;
        rdata.last = 1'b1;
        rdata.result_slot = cmd_r.slot;
        widx = tgt;
        if (cmd_r.func == msit_pkg::FN_CREATE) begin
          if (full_r) begin
            rdata.status = 1'b1; rdata.result_slot = 3'd0;
          end else begin
            rdata.result_slot = 3'(nf_r);
            widx = nf_r; wr_new = 1'b1;
            in_use_nxt[nf_r] = 1'b1; run_nxt[nf_r] = 1'b1;
            endl_nxt[nf_r] = (cmd_r.count == 16'd0);
            nf_nxt = srch; full_nxt = !srch_ok;
          end
        end else if (cmd_r.func > 4'(msit_pkg::FN_TICK)) begin
          rdata.status = 1'b1; rdata.result_slot = 3'd0;
        end else if (!tgt_ok) begin
          rdata.status = 1'b1;
        end else begin
          case (cmd_r.func)
            msit_pkg::FN_PAUSE:  run_nxt[tgt] = 1'b0;
            msit_pkg::FN_RESUME: run_nxt[tgt] = 1'b1;
            msit_pkg::FN_QUERY:  rdata.running = run_r[tgt];
            msit_pkg::FN_TRIGDEL, msit_pkg::FN_CANCEL: begin
              rdata.fired = (cmd_r.func == msit_pkg::FN_TRIGDEL);
              in_use_nxt[tgt] = 1'b0; nf_nxt = tgt; full_nxt = 1'b0;
            end
            msit_pkg::FN_SETCNT: begin wr_rem = 1'b1; rem_val = cmd_r.count; end
            msit_pkg::FN_SETIVL: begin
              wr_per = 1'b1; per_val = {16'd0, cmd_r.interval_ms[15:0]};
            end
            default: ;
          endcase
        end
      end
      msit_pkg::ST_SCAN: if (rq_room) begin
        idx_nxt = last_slot ? idx_r : idx_r + SW'(1);
        act = in_use_r[idx_r] && run_r[idx_r];
        if (act) begin
          wr_ela = 1'b1; ela_val = esum;
          fire = (esum >= per_r[idx_r]);
          if (fire) begin
            ela_val = '0;
            if (!endl_r[idx_r]) begin
              wr_rem = 1'b1; rem_val = rdec;
              if (rdec == 16'd0) begin
                wr_ela = 1'b0;
                in_use_nxt[idx_r] = 1'b0; nf_nxt = idx_r; full_nxt = 1'b0;
              end
            end
            if (nf_cnt_r < 4'(msit_pkg::MAX_FIRES)) begin
              nf_cnt_nxt = nf_cnt_r + 4'd1;
              if (pend_r) begin
                rpush = 1'b1; rdata.fired = 1'b1; rdata.result_slot = pend_slot_r;
              end
              pend_nxt = 1'b1; pend_slot_nxt = 3'(idx_r);
            end
          end
        end
      end
      msit_pkg::ST_FLUSH: if (rq_room && pend_r) begin
        rpush = 1'b1; rdata.fired = 1'b1; rdata.last = 1'b1;
        rdata.result_slot = pend_slot_r; pend_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= msit_pkg::ST_IDLE;
      in_use_r <= '0; run_r <= '0; endl_r <= '0;
      nf_r <= '0; full_r <= 1'b0; idx_r <= '0; nf_cnt_r <= '0; pend_r <= 1'b0;
      rwp_r <= 1'b0; rrp_r <= 1'b0; rcnt_r <= 2'd0;
      for (int i = 0; i < SLOTS; i++) begin
        rem_r[i] <= '0; per_r[i] <= '0; ela_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      in_use_r <= in_use_nxt; run_r <= run_nxt; endl_r <= endl_nxt;
      nf_r <= nf_nxt; full_r <= full_nxt; idx_r <= idx_nxt;
      nf_cnt_r <= nf_cnt_nxt; pend_r <= pend_nxt;
      rwp_r <= rpush ? ~rwp_r : rwp_r;
      rrp_r <= (pop && !empty) ? ~rrp_r : rrp_r;
      rcnt_r <= rcnt_r + 2'(rpush) - 2'(pop && !empty);
      if (wr_new) begin
        rem_r[widx] <= cmd_r.count; per_r[widx] <= cmd_r.interval_ms; ela_r[widx] <= '0;
      end
      if (wr_ela) ela_r[widx] <= ela_val;
      if (wr_rem) rem_r[widx] <= rem_val;
      if (wr_per) per_r[widx] <= per_val;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    if (q_take) cmd_r <= q_cmd;
    if (rpush) rq_r[rwp_r] <= rdata;
  end
endmodule
`default_nettype wire

// File: design/multi_slot_interval_timer_unit.sv
// Top level of the multi-slot interval timer.
//  channel | direction | handshake      | ports
//  input   | in        | push / full    | in_func in_slot in_count in_interval_ms in_tick_ms
//  result  | out       | empty / pop    | out_status out_result_slot out_fired out_running out_last
// A command is taken by the back end when it is idle; its result is pushed to the result
// queue once that has room; the back end takes no new command until it is idle again.
// A tick is taken, scanned one slot a cycle while the result queue has room, then flushed;
// each fire is held one step so the final one carries last.
// A stalled result queue (two entries) holds the back end; the front keeps filling.
// Reset (rst_n low, synchronous) clears every slot and both queues at once.
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_interval_timer_unit #(
  parameter int SLOTS = msit_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [3:0]  in_func,
  input  wire logic [2:0]  in_slot,
  input  wire logic [15:0] in_count,
  input  wire logic [31:0] in_interval_ms,
  input  wire logic [31:0] in_tick_ms,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_status,
  output logic [2:0]       out_result_slot,
  output logic             out_fired,
  output logic             out_running,
  output logic             out_last
);
  msit_pkg::cmd_t in_cmd, q_cmd;
  msit_pkg::res_t res;
  logic q_valid, q_take, busy;

  assign in_cmd = '{func: in_func, slot: in_slot, count: in_count,
                    interval_ms: in_interval_ms, tick_ms: in_tick_ms};

  msit_front u_front (
    .clk, .rst_n, .push, .full, .in_cmd, .q_valid, .q_cmd, .q_take, .busy
  );

  msit_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take, .empty, .pop, .res
  );

  assign out_status      = res.status;
  assign out_result_slot = res.result_slot;
  assign out_fired       = res.fired;
  assign out_running     = res.running;
  assign out_last        = res.last;

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> busy) else $error("back end took from an empty queue");
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_fired) |-> !out_status && !out_running)
    else $error("fire result with error or running flag");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty) else $error("result vanished without pop");
endmodule
`default_nettype wire
